>>> hdl/sldp_pkg.sv
// Shared types and constants for the symbolic LUT dot-product unit.
// Used by every module of the block; no dependencies.
`default_nettype none

package sldp_pkg;

	localparam int SYM_W = 7;
	localparam int OPC_W = 3;

	// Parameter defaults for the top level
	localparam int SYMBOLS_DEF        = 128;
	localparam int WEIGHT_SYMBOLS_DEF = 128;
	localparam int NEURONS_DEF        = 128;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD_PROD = 3'd0,
		OP_LOAD_SUM  = 3'd1,
		OP_LOAD_BIAS = 3'd2,
		OP_LOAD_RELU = 3'd3,
		OP_TERM      = 3'd4
	} op_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [SYM_W-1:0] table_row;
		logic [SYM_W-1:0] table_col;
		logic [SYM_W-1:0] table_value;
		logic [SYM_W-1:0] activation_symbol;
		logic [SYM_W-1:0] weight_symbol;
		logic [SYM_W-1:0] neuron_index;
		logic             last_term;
	} in_t;

	typedef struct packed {
		logic [SYM_W-1:0] result_symbol;
		logic [SYM_W-1:0] result_neuron;
	} out_t;

	// Classified command: loads use a=row, b=col, c=value;
	// terms use a=activation, b=weight, c=neuron.
	typedef struct packed {
		op_t              op;
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] b;
		logic [SYM_W-1:0] c;
		logic             last;
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/sldp_front.sv
// Front end: accepts input transactions, decodes the opcode and drops no-ops.
// Depends on sldp_pkg.
`default_nettype none

module sldp_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  sldp_pkg::in_t     in_data,
	output logic              cmd_valid,
	input  wire               cmd_ready,
	output sldp_pkg::cmd_t    cmd
);

	sldp_pkg::cmd_t cmd_d;
	sldp_pkg::cmd_t cmd_q;
	logic           keep;
	logic           cmd_valid_q;

	assign in_ready  = !cmd_valid_q || cmd_ready;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_comb begin
		keep       = 1'b1;
		cmd_d.op   = sldp_pkg::OP_TERM;
		cmd_d.a    = in_data.table_row;
		cmd_d.b    = in_data.table_col;
		cmd_d.c    = in_data.table_value;
		cmd_d.last = in_data.last_term;
		case (in_data.opcode)
			sldp_pkg::OP_LOAD_PROD: cmd_d.op = sldp_pkg::OP_LOAD_PROD;
			sldp_pkg::OP_LOAD_SUM:  cmd_d.op = sldp_pkg::OP_LOAD_SUM;
			sldp_pkg::OP_LOAD_BIAS: cmd_d.op = sldp_pkg::OP_LOAD_BIAS;
			sldp_pkg::OP_LOAD_RELU: cmd_d.op = sldp_pkg::OP_LOAD_RELU;
			sldp_pkg::OP_TERM: begin
				cmd_d.op = sldp_pkg::OP_TERM;
				cmd_d.a  = in_data.activation_symbol;
				cmd_d.b  = in_data.weight_symbol;
				cmd_d.c  = in_data.neuron_index;
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (in_ready) begin
			cmd_valid_q <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/sldp_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on sldp_pkg.
`default_nettype none

module sldp_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push_valid,
	output logic              push_ready,
	input  sldp_pkg::cmd_t    push_data,
	output logic              pop_valid,
	input  wire               pop_ready,
	output sldp_pkg::cmd_t    pop_data
);

	sldp_pkg::cmd_t                     entry_q [sldp_pkg::FIFO_DEPTH];
	logic [sldp_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [sldp_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [sldp_pkg::FIFO_AW:0]         count_q;
	logic                               push;
	logic                               pop;

	assign push_ready = count_q != (sldp_pkg::FIFO_AW+1)'(sldp_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hdl/sldp_back.sv
// Back end: table memories, accumulator loop, bias/ReLU stages and output register.
// Depends on sldp_pkg.
`default_nettype none

module sldp_back #(
	parameter int SYMBOLS        = sldp_pkg::SYMBOLS_DEF,
	parameter int WEIGHT_SYMBOLS = sldp_pkg::WEIGHT_SYMBOLS_DEF,
	parameter int NEURONS        = sldp_pkg::NEURONS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire               cfg_wr_data,
	input  wire               cmd_valid,
	output logic              cmd_ready,
	input  sldp_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  wire               out_ready,
	output sldp_pkg::out_t    out_data
);

	localparam int SW   = sldp_pkg::SYM_W;
	localparam int IW   = 2 * SW;
	localparam int SMAX = 1 << SW;
	// Only indices reachable through the 7-bit fields need storage
	localparam int SYM_N = (SYMBOLS < SMAX) ? SYMBOLS : SMAX;
	localparam int WGT_N = (WEIGHT_SYMBOLS < SMAX) ? WEIGHT_SYMBOLS : SMAX;
	localparam int NRN_N = (NEURONS < SMAX) ? NEURONS : SMAX;
	localparam int PROD_DEPTH = SYM_N * WGT_N;
	localparam int SUM_DEPTH  = SYM_N * SYM_N;
	localparam int BIAS_DEPTH = SYM_N * NRN_N;
	localparam int PROD_AW = (PROD_DEPTH > 1) ? $clog2(PROD_DEPTH) : 1;
	localparam int SUM_AW  = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
	localparam int BIAS_AW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
	localparam int RELU_AW = (SYM_N > 1) ? $clog2(SYM_N) : 1;

	logic [SW-1:0] prod_mem [PROD_DEPTH];
	logic [SW-1:0] sum_mem  [SUM_DEPTH];
	logic [SW-1:0] bias_mem [BIAS_DEPTH];
	logic [SW-1:0] relu_mem [SYM_N];

	logic [SW-1:0] prod_rd;
	logic [SW-1:0] sum_rd;
	logic [SW-1:0] bias_rd;
	logic [SW-1:0] relu_rd;

	logic           relu_en_q;
	logic           adv;
	logic           pop;

	logic           v_s1, v_s2, v_s3, v_s4;
	sldp_pkg::cmd_t cmd_s1, cmd_s2, cmd_s3;
	logic           pok_s1;
	logic           bok_s3;
	logic [SW-1:0]  sym_s4;
	logic [SW-1:0]  neu_s4;
	logic           rel_s4;
	logic           rok_s4;

	logic           first_q;
	logic [SW-1:0]  acc_q;
	logic           pend_q;
	logic           sok_q;
	logic [SW-1:0]  acc_cur;

	logic           out_valid_q;
	sldp_pkg::out_t out_q;

	logic [SW-1:0]  prod_val;
	logic [SW-1:0]  bias_val;
	logic           term_b;
	logic           term_last_c;
	logic           term_last_d;
	logic [IW-1:0]  prod_idx;
	logic [IW-1:0]  sum_widx;
	logic [IW-1:0]  sum_ridx;
	logic [IW-1:0]  bias_widx;
	logic [IW-1:0]  bias_ridx;

	function automatic logic pok_a();
		return ({1'b0, cmd.a} < (SW+1)'(SYM_N)) && ({1'b0, cmd.b} < (SW+1)'(WGT_N));
	endfunction

	// Whole back pipeline moves together; only the output register can stall it
	assign adv       = !out_valid_q || out_ready;
	assign cmd_ready = adv;
	assign pop       = cmd_valid && adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			relu_en_q <= cfg_wr_data;
		end
	end

	// ---- stage A: product table ----
	assign prod_idx = IW'(cmd.a) * IW'(WGT_N) + IW'(cmd.b);

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd.op == sldp_pkg::OP_LOAD_PROD && pok_a()) begin
				prod_mem[prod_idx[PROD_AW-1:0]] <= cmd.c;
			end
			if (cmd.op == sldp_pkg::OP_TERM) begin
				prod_rd <= prod_mem[prod_idx[PROD_AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
			pok_s1 <= pok_a();
		end
	end

	// ---- stage B: accumulator loop through the sum table ----
	// The registered sum-table output feeds the next term's address directly.
	assign prod_val = pok_s1 ? prod_rd : '0;
	assign acc_cur  = pend_q ? (sok_q ? sum_rd : '0) : acc_q;
	assign term_b   = v_s1 && cmd_s1.op == sldp_pkg::OP_TERM;
	assign sum_ridx = IW'(acc_cur) * IW'(SYM_N) + IW'(prod_val);
	assign sum_widx = IW'(cmd_s1.a) * IW'(SYM_N) + IW'(cmd_s1.b);

	always_ff @(posedge clk) begin
		if (adv && v_s1 && cmd_s1.op == sldp_pkg::OP_LOAD_SUM
			&& {1'b0, cmd_s1.a} < (SW+1)'(SYM_N)
			&& {1'b0, cmd_s1.b} < (SW+1)'(SYM_N)) begin
			sum_mem[sum_widx[SUM_AW-1:0]] <= cmd_s1.c;
		end
		if (adv && term_b && !first_q) begin
			sum_rd <= sum_mem[sum_ridx[SUM_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			acc_q   <= '0;
			pend_q  <= 1'b0;
			sok_q   <= 1'b0;
			v_s2    <= 1'b0;
		end else if (adv) begin
			v_s2   <= v_s1;
			pend_q <= term_b && !first_q;
			sok_q  <= ({1'b0, acc_cur} < (SW+1)'(SYM_N))
				&& ({1'b0, prod_val} < (SW+1)'(SYM_N));
			acc_q  <= (term_b && first_q) ? prod_val : acc_cur;
			if (term_b) begin
				first_q <= cmd_s1.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
		end
	end

	// ---- stage C: bias table ----
	assign term_last_c = v_s2 && cmd_s2.op == sldp_pkg::OP_TERM && cmd_s2.last;
	assign bias_ridx   = IW'(acc_cur) * IW'(NRN_N) + IW'(cmd_s2.c);
	assign bias_widx   = IW'(cmd_s2.a) * IW'(NRN_N) + IW'(cmd_s2.b);

	always_ff @(posedge clk) begin
		if (adv && v_s2 && cmd_s2.op == sldp_pkg::OP_LOAD_BIAS
			&& {1'b0, cmd_s2.a} < (SW+1)'(SYM_N)
			&& {1'b0, cmd_s2.b} < (SW+1)'(NRN_N)) begin
			bias_mem[bias_widx[BIAS_AW-1:0]] <= cmd_s2.c;
		end
		if (adv && term_last_c) begin
			bias_rd <= bias_mem[bias_ridx[BIAS_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3 <= cmd_s2;
			bok_s3 <= ({1'b0, acc_cur} < (SW+1)'(SYM_N))
				&& ({1'b0, cmd_s2.c} < (SW+1)'(NRN_N));
		end
	end

	// ---- stage D: ReLU table ----
	assign bias_val    = bok_s3 ? bias_rd : '0;
	assign term_last_d = v_s3 && cmd_s3.op == sldp_pkg::OP_TERM && cmd_s3.last;

	always_ff @(posedge clk) begin
		if (adv && v_s3 && cmd_s3.op == sldp_pkg::OP_LOAD_RELU
			&& {1'b0, cmd_s3.a} < (SW+1)'(SYM_N)) begin
			relu_mem[cmd_s3.a[RELU_AW-1:0]] <= cmd_s3.c;
		end
		if (adv && term_last_d && relu_en_q) begin
			relu_rd <= relu_mem[bias_val[RELU_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= term_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sym_s4 <= bias_val;
			neu_s4 <= cmd_s3.c;
			rel_s4 <= relu_en_q;
			rok_s4 <= {1'b0, bias_val} < (SW+1)'(SYM_N);
		end
	end

	// ---- stage E: output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			out_q.result_symbol <= rel_s4 ? (rok_s4 ? relu_rd : '0) : sym_s4;
			out_q.result_neuron <= neu_s4;
		end
	end

endmodule

`default_nettype wire

>>> hdl/symbolic_lut_dot_product_unit.sv
// Top level of the symbolic LUT dot-product unit.
// Depends on sldp_pkg, sldp_front, sldp_queue and sldp_back.
`default_nettype none

// One input transaction per clock is accepted at the sustained rate, loads and
// terms alike, including runs of back-to-back terms: the sum table's registered
// read data drives the next term's sum-table address directly, and that
// accumulator loop sets the rate. A term marked last gives its result after
// the input register, queue, product, sum, bias and ReLU reads and output
// register; other transactions give none. A result held by out_ready low
// freezes the back end until it is taken. Tables hold whatever was last written
// and are not cleared by reset, so no clearing pass is needed. relu_enable must
// be written through cfg_wr_en only while idle; the block does not enforce it.
module symbolic_lut_dot_product_unit #(
	parameter int SYMBOLS        = sldp_pkg::SYMBOLS_DEF,
	parameter int WEIGHT_SYMBOLS = sldp_pkg::WEIGHT_SYMBOLS_DEF,
	parameter int NEURONS        = sldp_pkg::NEURONS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire               cfg_wr_data,
	input  wire               in_valid,
	output logic              in_ready,
	input  sldp_pkg::in_t     in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output sldp_pkg::out_t    out_data
);

	logic           f_valid, f_ready;
	sldp_pkg::cmd_t f_cmd;
	logic           q_valid, q_ready;
	sldp_pkg::cmd_t q_cmd;

	sldp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	sldp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	sldp_back #(
		.SYMBOLS        (SYMBOLS),
		.WEIGHT_SYMBOLS (WEIGHT_SYMBOLS),
		.NEURONS        (NEURONS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (q_valid),
		.cmd_ready   (q_ready),
		.cmd         (q_cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

>>> hdl/sldp_checker.sv
// Port-level checks for the symbolic LUT dot-product unit, bound to the top level.
// Depends on sldp_pkg and symbolic_lut_dot_product_unit.
`default_nettype none

module sldp_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            in_ready,
	input sldp_pkg::out_t out_data,
	input wire            out_valid,
	input wire            out_ready
);

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A result only leaves when it was taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without acceptance");

	// Nothing is reported while held in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	// Front end is empty and ready right after reset
	a_ready_after_reset: assert property (@(posedge clk)
		$past(!arst_n) && arst_n |-> in_ready)
		else $error("input not ready after reset");

endmodule

bind symbolic_lut_dot_product_unit sldp_checker u_sldp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_data  (out_data),
	.out_valid (out_valid),
	.out_ready (out_ready)
);

`default_nettype wire

>>> dv/symbolic_lut_dot_product_unit_test.sv
// Self-checking testbench for symbolic_lut_dot_product_unit: directed and random
// table loads and dot-product terms, results checked by an in-bench lookup predictor.
// Depends on sldp_pkg and the RTL of the unit.

module symbolic_lut_dot_product_unit_test;

	typedef logic [sldp_pkg::SYM_W-1:0] sym_t;
	typedef logic [2*sldp_pkg::SYM_W-1:0] pair_t;
	typedef logic [sldp_pkg::OPC_W-1:0] opc_t;

	localparam int ENTRIES = 1 << (2 * sldp_pkg::SYM_W);
	localparam int RELU_ENTRIES = 1 << sldp_pkg::SYM_W;
	localparam sym_t SYM_MAX = '1;
	localparam opc_t OP_SPARE_LO = 3'd5;
	localparam opc_t OP_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_MAX = 10;
	localparam int PHASE_ITEMS = 450;

	class dot_product_scoreboard;
		sym_t prod_lut[ENTRIES];
		sym_t sum_lut[ENTRIES];
		sym_t bias_lut[ENTRIES];
		sym_t rect_map[RELU_ENTRIES];
		bit prod_set[ENTRIES];
		bit sum_set[ENTRIES];
		bit bias_set[ENTRIES];
		bit relu_set[RELU_ENTRIES];
		pair_t prod_keys[$];
		sym_t acc_sym = '0;
		bit run_start = 1'b1;
		bit relu_en = 1'b0;
		sldp_pkg::out_t pending_results[$];
		int mismatches = 0;

		function void take_input(sldp_pkg::in_t it);
			sym_t prod;
			sym_t res;
			case (it.opcode)
			sldp_pkg::OP_LOAD_PROD: begin
				if (!prod_set[{it.table_row, it.table_col}])
					prod_keys.push_back({it.table_row, it.table_col});
				prod_set[{it.table_row, it.table_col}] = 1'b1;
				prod_lut[{it.table_row, it.table_col}] = it.table_value;
			end
			sldp_pkg::OP_LOAD_SUM: begin
				sum_set[{it.table_row, it.table_col}] = 1'b1;
				sum_lut[{it.table_row, it.table_col}] = it.table_value;
			end
			sldp_pkg::OP_LOAD_BIAS: begin
				bias_set[{it.table_row, it.table_col}] = 1'b1;
				bias_lut[{it.table_row, it.table_col}] = it.table_value;
			end
			sldp_pkg::OP_LOAD_RELU: begin
				relu_set[it.table_row] = 1'b1;
				rect_map[it.table_row] = it.table_value;
			end
			sldp_pkg::OP_TERM: begin
				prod = prod_lut[{it.activation_symbol, it.weight_symbol}];
				acc_sym = run_start ? prod : sum_lut[{acc_sym, prod}];
				run_start = it.last_term;
				if (it.last_term) begin
					res = bias_lut[{acc_sym, it.neuron_index}];
					if (relu_en)
						res = rect_map[res];
					pending_results.push_back(sldp_pkg::out_t'{res, it.neuron_index});
				end
			end
			default: ;
			endcase
		endfunction

		function void note_mismatch(string what, sldp_pkg::out_t want,
				sldp_pkg::out_t got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%s: expected symbol %0d neuron %0d, got symbol %0d neuron %0d",
					what, want.result_symbol, want.result_neuron,
					got.result_symbol, got.result_neuron);
		endfunction

		function void check_result(sldp_pkg::out_t got);
			sldp_pkg::out_t want;
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.result_symbol !== want.result_symbol ||
					got.result_neuron !== want.result_neuron)
				note_mismatch("result mismatch", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic in_valid;
	logic in_ready;
	sldp_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	sldp_pkg::out_t out_data;

	dot_product_scoreboard board;
	int send_idle_pct;
	int recv_stall_pct;
	bit long_hold_req;
	int items_sent;

	symbolic_lut_dot_product_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("symbolic_lut_dot_product_unit verification failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic sym_t rand_sym();
		// half from a small pool so sum-table entries get reused
		if ($urandom_range(99) < 50)
			return sym_t'($urandom_range(7));
		return sym_t'($urandom_range(SYM_MAX));
	endfunction

	function automatic sldp_pkg::in_t make_item(opc_t opcode);
		logic [63:0] noise;
		sldp_pkg::in_t it;
		noise = {$urandom, $urandom};
		it = noise[$bits(sldp_pkg::in_t)-1:0];
		it.opcode = opcode;
		return it;
	endfunction

	function automatic sldp_pkg::in_t make_load(sldp_pkg::op_t op, sym_t row, sym_t col,
			sym_t value);
		sldp_pkg::in_t it;
		it = make_item(op);
		it.table_row = row;
		it.table_col = col;
		it.table_value = value;
		return it;
	endfunction

	function automatic sldp_pkg::in_t make_term(sym_t act, sym_t wgt, sym_t neuron,
			bit last);
		sldp_pkg::in_t it;
		it = make_item(sldp_pkg::OP_TERM);
		it.activation_symbol = act;
		it.weight_symbol = wgt;
		it.neuron_index = neuron;
		it.last_term = last;
		return it;
	endfunction

	// Entered and left just after a falling edge.
	task automatic send_item(sldp_pkg::in_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.take_input(it);
		if (it.opcode <= sldp_pkg::OP_TERM)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic load_entry(sldp_pkg::op_t op, sym_t row, sym_t col);
		send_item(make_load(op, row, col, rand_sym()));
	endtask

	// Writes any table entries the term is about to read that were never loaded, then sends the term.
	task automatic play_term(sym_t act, sym_t wgt, sym_t neuron, bit last);
		sym_t prod;
		sym_t nxt;
		sym_t biased;
		if (!board.prod_set[{act, wgt}])
			load_entry(sldp_pkg::OP_LOAD_PROD, act, wgt);
		prod = board.prod_lut[{act, wgt}];
		if (board.run_start)
			nxt = prod;
		else begin
			if (!board.sum_set[{board.acc_sym, prod}])
				load_entry(sldp_pkg::OP_LOAD_SUM, board.acc_sym, prod);
			nxt = board.sum_lut[{board.acc_sym, prod}];
		end
		if (last) begin
			if (!board.bias_set[{nxt, neuron}])
				load_entry(sldp_pkg::OP_LOAD_BIAS, nxt, neuron);
			biased = board.bias_lut[{nxt, neuron}];
			if (board.relu_en && !board.relu_set[biased])
				load_entry(sldp_pkg::OP_LOAD_RELU, biased, rand_sym());
		end
		send_item(make_term(act, wgt, neuron, last));
	endtask

	task automatic noise_item();
		sldp_pkg::op_t op;
		if ($urandom_range(99) < 25)
			send_item(make_item(opc_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
		else begin
			op = sldp_pkg::op_t'($urandom_range(sldp_pkg::OP_LOAD_RELU));
			send_item(make_load(op, sym_t'($urandom_range(SYM_MAX)),
				sym_t'($urandom_range(SYM_MAX)), sym_t'($urandom_range(SYM_MAX))));
		end
	endtask

	task automatic run_dot(int len, bit finish);
		sym_t act;
		sym_t wgt;
		sym_t neuron;
		pair_t key;
		neuron = sym_t'($urandom_range(SYM_MAX));
		for (int i = 0; i < len; i++) begin
			if (board.prod_keys.size() != 0 && $urandom_range(99) < 75) begin
				key = board.prod_keys[$urandom_range(board.prod_keys.size() - 1)];
				act = key[2*sldp_pkg::SYM_W-1:sldp_pkg::SYM_W];
				wgt = key[sldp_pkg::SYM_W-1:0];
			end else begin
				act = sym_t'($urandom_range(SYM_MAX));
				wgt = sym_t'($urandom_range(SYM_MAX));
			end
			// stray loads or spare opcodes in the middle of a run
			if ($urandom_range(99) < 8)
				noise_item();
			play_term(act, wgt, neuron, finish && i == len - 1);
		end
	endtask

	// Loads give no result, so allow the pipeline to empty after the last one.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_relu_enable(bit value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		board.relu_en = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		int phase_end;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold_req = 1'b0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corner symbols, ReLU off from reset
		send_item(make_load(sldp_pkg::OP_LOAD_PROD, '0, '0, SYM_MAX));
		send_item(make_load(sldp_pkg::OP_LOAD_PROD, SYM_MAX, SYM_MAX, '0));
		send_item(make_load(sldp_pkg::OP_LOAD_PROD, SYM_MAX, '0, 7'h55));
		send_item(make_load(sldp_pkg::OP_LOAD_PROD, '0, SYM_MAX, 7'h2a));
		play_term('0, '0, SYM_MAX, 1'b1);
		play_term(SYM_MAX, SYM_MAX, '0, 1'b0);
		play_term('0, '0, '0, 1'b1);
		play_term(SYM_MAX, '0, SYM_MAX, 1'b0);
		send_item(make_load(sldp_pkg::OP_LOAD_RELU, SYM_MAX, '0, SYM_MAX));
		play_term('0, SYM_MAX, SYM_MAX, 1'b1);
		for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
			send_item(make_item(opc_t'(op)));
		drain();
		write_relu_enable(1'b1);
		play_term(SYM_MAX, SYM_MAX, '0, 1'b1);
		play_term('0, '0, SYM_MAX, 1'b0);
		play_term(SYM_MAX, '0, '0, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			write_relu_enable(phase % 2 == 0);
			case (phase)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				long_hold_req = 1'b1;
			end
			1: begin
				send_idle_pct = 64;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 64;
			end
			default: begin
				send_idle_pct = 34;
				recv_stall_pct = 34;
			end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 80)
					run_dot(($urandom_range(99) < 85) ? $urandom_range(1, 5)
						: $urandom_range(6, 16), $urandom_range(99) >= 5);
				else
					noise_item();
			end
		end

		drain();
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("symbolic_lut_dot_product_unit verification clean");
		else
			$display("symbolic_lut_dot_product_unit verification failed");
		$finish;
	end

endmodule
